>>> rtl/core/stcd_pkg.sv
package stcd_pkg;

    // Pipeline depth: four stages split the timestamp into days and seconds of the day,
    // nine more stages derive the date and the time of day side by side.
    localparam int NUM_STAGES = 13;

    // Stage positions of the front split.
    localparam int ST_ADD  = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_BACK = 2;
    localparam int ST_FIX  = 3;

    // First stage of the date and time-of-day branches.
    localparam int ST_TAIL = 4;

    // One load enable per pipeline stage.
    typedef logic [NUM_STAGES-1:0] t_stage_en;

endpackage

>>> rtl/core/stcd_split.sv
module stcd_split (
    input  logic                i_clk,
    input  stcd_pkg::t_stage_en i_en,
    input  logic [31:0]         i_seconds,
    output logic [15:0]         o_days,
    output logic [16:0]         o_sod
);
    import stcd_pkg::*;

    localparam logic [31:0] EPOCH_OFFSET = 32'd946684800;
    localparam logic [31:0] SECS_PER_DAY = 32'd86400;
    // floor(2^32 / 86400); the estimate is at most one below the true quotient.
    localparam logic [47:0] DAY_RECIP    = 48'd49710;

    logic [31:0] r_t0;
    logic [31:0] r_t1;
    logic [15:0] r_dq1;
    logic [15:0] r_dq2;
    logic [17:0] r_drem;
    logic [15:0] r_days;
    logic [16:0] r_sod;

    logic [31:0] n_t;
    logic [47:0] n_dprod;
    logic [31:0] n_dback;
    logic [31:0] n_ddiff;
    logic        n_dfix;
    logic [17:0] n_dsub;
    logic [15:0] n_days;
    logic [16:0] n_sod;

    // Move the count to the 1970 epoch, wrapping at 32 bits.
    assign n_t = i_seconds + EPOCH_OFFSET;

    // Reciprocal estimate of the day number.
    assign n_dprod = {16'd0, r_t0} * DAY_RECIP;

    // Remainder against the estimate, below twice the day length.
    assign n_dback = {16'd0, r_dq1} * SECS_PER_DAY;
    assign n_ddiff = r_t1 - n_dback;

    // One correction step gives the exact day number and seconds of the day.
    always_comb begin
        n_dfix = (r_drem >= SECS_PER_DAY[17:0]);
        n_dsub = r_drem - SECS_PER_DAY[17:0];
        n_days = r_dq2 + {15'd0, n_dfix};
        n_sod  = n_dfix ? n_dsub[16:0] : r_drem[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_ADD]) begin
            r_t0 <= n_t;
        end
        if (i_en[ST_MUL]) begin
            r_t1  <= r_t0;
            r_dq1 <= n_dprod[47:32];
        end
        if (i_en[ST_BACK]) begin
            r_dq2  <= r_dq1;
            r_drem <= n_ddiff[17:0];
        end
        if (i_en[ST_FIX]) begin
            r_days <= n_days;
            r_sod  <= n_sod;
        end
    end

    assign o_days = r_days;
    assign o_sod  = r_sod;

endmodule

>>> rtl/core/stcd_date.sv
module stcd_date (
    input  logic                i_clk,
    input  stcd_pkg::t_stage_en i_en,
    input  logic [15:0]         i_days,
    output logic [11:0]         o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day
);
    import stcd_pkg::*;

    // Century that the day falls in.
    localparam logic [1:0] CENT_19 = 2'd0;
    localparam logic [1:0] CENT_20 = 2'd1;
    localparam logic [1:0] CENT_21 = 2'd2;

    // Day numbers where the century index steps up.
    localparam logic [15:0] DAYS_CENT_20 = 16'd11017;
    localparam logic [15:0] DAYS_CENT_21 = 16'd47541;

    // Day within the century plus one, for each century.
    localparam logic [16:0] ADD_CENT_19 = 17'd25509;
    localparam logic [16:0] SUB_CENT_20 = 17'd11016;
    localparam logic [16:0] SUB_CENT_21 = 17'd47540;

    // Year-in-century division: 4000 * x / 1461001.
    localparam logic [23:0] YR_RECIP  = 24'd179;
    localparam logic [27:0] YR_MUL    = 28'd4000;
    localparam logic [27:0] YR_DIV    = 28'd1461001;
    localparam logic [17:0] YR_DAYS4  = 18'd1461;

    // Month division: 80 * l / 2447.
    localparam logic [15:0] MO_RECIP  = 16'd33;
    localparam logic [16:0] MO_MUL    = 17'd80;
    localparam logic [16:0] MO_DIV    = 17'd2447;
    localparam logic [3:0]  MO_WRAP   = 4'd11;

    localparam int DT0 = ST_TAIL;
    localparam int DT1 = ST_TAIL + 1;
    localparam int DT2 = ST_TAIL + 2;
    localparam int DT3 = ST_TAIL + 3;
    localparam int DT4 = ST_TAIL + 4;
    localparam int DT5 = ST_TAIL + 5;
    localparam int DT6 = ST_TAIL + 6;
    localparam int DT7 = ST_TAIL + 7;
    localparam int DT8 = ST_TAIL + 8;

    // Days before the first of each month slot, counted from March: floor(2447 * j / 80).
    function automatic logic [9:0] month_start(input logic [3:0] j);
        logic [9:0] v;
        unique case (j)
            4'd0:    v = 10'd0;
            4'd1:    v = 10'd30;
            4'd2:    v = 10'd61;
            4'd3:    v = 10'd91;
            4'd4:    v = 10'd122;
            4'd5:    v = 10'd152;
            4'd6:    v = 10'd183;
            4'd7:    v = 10'd214;
            4'd8:    v = 10'd244;
            4'd9:    v = 10'd275;
            4'd10:   v = 10'd305;
            4'd11:   v = 10'd336;
            4'd12:   v = 10'd367;
            4'd13:   v = 10'd397;
            4'd14:   v = 10'd428;
            default: v = 10'd458;
        endcase
        return v;
    endfunction

    logic [1:0]  r_cent [DT0:DT7];
    logic [15:0] r_x1;
    logic [15:0] r_x2;
    logic [15:0] r_x3;
    logic [15:0] r_x4;
    logic [6:0]  r_iq2;
    logic [6:0]  r_iq3;
    logic [21:0] r_irem;
    logic [6:0]  r_i   [DT4:DT8];
    logic [9:0]  r_l3  [DT5:DT8];
    logic [3:0]  r_jq6;
    logic [3:0]  r_jq7;
    logic [12:0] r_jrem;
    logic [3:0]  r_j;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    logic [1:0]  n_cent;
    logic [16:0] n_xw;
    logic [23:0] n_iprod;
    logic [27:0] n_inum;
    logic [27:0] n_iback;
    logic [27:0] n_idiff;
    logic [6:0]  n_i;
    logic [17:0] n_ispan;
    logic [16:0] n_l3w;
    logic [15:0] n_jprod;
    logic [16:0] n_jnum;
    logic [16:0] n_jback;
    logic [16:0] n_jdiff;
    logic [3:0]  n_j;
    logic        n_wrap;
    logic [9:0]  n_kw;
    logic [11:0] n_base;
    logic [11:0] n_year;
    logic [3:0]  n_month;

    // Select the century and the day within it.
    always_comb begin
        priority if (i_days >= DAYS_CENT_21) begin
            n_cent = CENT_21;
            n_xw   = {1'b0, i_days} - SUB_CENT_21;
        end else if (i_days >= DAYS_CENT_20) begin
            n_cent = CENT_20;
            n_xw   = {1'b0, i_days} - SUB_CENT_20;
        end else begin
            n_cent = CENT_19;
            n_xw   = {1'b0, i_days} + ADD_CENT_19;
        end
    end

    // Year within the century: reciprocal estimate, remainder, one correction.
    assign n_iprod = {8'd0, r_x1} * YR_RECIP;
    assign n_inum  = {12'd0, r_x2} * YR_MUL;
    assign n_iback = {21'd0, r_iq2} * YR_DIV;
    assign n_idiff = n_inum - n_iback;
    assign n_i     = r_iq3 + {6'd0, (r_irem >= YR_DIV[21:0])};

    // Day of the year counted from the March before it, offset by 31.
    assign n_ispan = {11'd0, r_i[DT4]} * YR_DAYS4;
    assign n_l3w   = {1'b0, r_x4} + 17'd30 - {1'b0, n_ispan[17:2]};

    // Month slot: reciprocal estimate, remainder, one correction.
    assign n_jprod = {6'd0, r_l3[DT5]} * MO_RECIP;
    assign n_jnum  = {7'd0, r_l3[DT6]} * MO_MUL;
    assign n_jback = {13'd0, r_jq6} * MO_DIV;
    assign n_jdiff = n_jnum - n_jback;
    assign n_j     = r_jq7 + {3'd0, (r_jrem >= MO_DIV[12:0])};

    // Final calendar fields; slots past December belong to the next year.
    always_comb begin
        n_wrap  = (r_j >= MO_WRAP);
        n_kw    = r_l3[DT8] - month_start(r_j);
        n_month = n_wrap ? (r_j - 4'd10) : (r_j + 4'd2);
        unique case (r_cent[DT7])
            CENT_19: n_base = 12'd1900;
            CENT_20: n_base = 12'd2000;
            CENT_21: n_base = 12'd2100;
            default: n_base = 12'd1900;
        endcase
        n_year = n_base + {5'd0, r_i[DT8]} + {11'd0, n_wrap};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DT0]) begin
            r_cent[DT0] <= n_cent;
            r_x1        <= n_xw[15:0];
        end
        if (i_en[DT1]) begin
            r_cent[DT1] <= r_cent[DT0];
            r_x2        <= r_x1;
            r_iq2       <= n_iprod[22:16];
        end
        if (i_en[DT2]) begin
            r_cent[DT2] <= r_cent[DT1];
            r_x3        <= r_x2;
            r_iq3       <= r_iq2;
            r_irem      <= n_idiff[21:0];
        end
        if (i_en[DT3]) begin
            r_cent[DT3] <= r_cent[DT2];
            r_x4        <= r_x3;
            r_i[DT4]    <= n_i;
        end
        if (i_en[DT4]) begin
            r_cent[DT4] <= r_cent[DT3];
            r_i[DT5]    <= r_i[DT4];
            r_l3[DT5]   <= n_l3w[9:0];
        end
        if (i_en[DT5]) begin
            r_cent[DT5] <= r_cent[DT4];
            r_i[DT6]    <= r_i[DT5];
            r_l3[DT6]   <= r_l3[DT5];
            r_jq6       <= n_jprod[13:10];
        end
        if (i_en[DT6]) begin
            r_cent[DT6] <= r_cent[DT5];
            r_i[DT7]    <= r_i[DT6];
            r_l3[DT7]   <= r_l3[DT6];
            r_jq7       <= r_jq6;
            r_jrem      <= n_jdiff[12:0];
        end
        if (i_en[DT7]) begin
            r_cent[DT7] <= r_cent[DT6];
            r_i[DT8]    <= r_i[DT7];
            r_l3[DT8]   <= r_l3[DT7];
            r_j         <= n_j;
        end
        if (i_en[DT8]) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_kw[4:0];
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

>>> rtl/core/stcd_tod.sv
module stcd_tod (
    input  logic                i_clk,
    input  stcd_pkg::t_stage_en i_en,
    input  logic [16:0]         i_sod,
    output logic [4:0]          o_hour,
    output logic [5:0]          o_minute,
    output logic [5:0]          o_second
);
    import stcd_pkg::*;

    // floor(2^17 / 3600) and floor(2^12 / 60); each estimate is at most one low.
    localparam logic [22:0] HR_RECIP  = 23'd36;
    localparam logic [16:0] SECS_HOUR = 17'd3600;
    localparam logic [18:0] MN_RECIP  = 19'd68;
    localparam logic [11:0] SECS_MIN  = 12'd60;

    localparam int TD0 = ST_TAIL;
    localparam int TD1 = ST_TAIL + 1;
    localparam int TD2 = ST_TAIL + 2;
    localparam int TD3 = ST_TAIL + 3;
    localparam int TD4 = ST_TAIL + 4;
    localparam int TD5 = ST_TAIL + 5;
    // Delay stages that line the time of day up with the date branch.
    localparam int TDLY_FIRST = ST_TAIL + 6;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    logic [16:0] r_sod1;
    logic [4:0]  r_hq1;
    logic [4:0]  r_hq2;
    logic [12:0] r_hrem;
    logic [4:0]  r_hour [TD3:TD5];
    logic [11:0] r_mrem2_3;
    logic [11:0] r_mrem2_4;
    logic [5:0]  r_mq;
    logic [5:0]  r_mq4;
    logic [6:0]  r_srem;
    t_tod        r_dly [TD5:NUM_STAGES-1];

    logic [22:0] n_hprod;
    logic [16:0] n_hback;
    logic [16:0] n_hdiff;
    logic        n_hfix;
    logic [12:0] n_hsub;
    logic [4:0]  n_hour;
    logic [11:0] n_mrem;
    logic [18:0] n_mprod;
    logic [11:0] n_mback;
    logic [11:0] n_mdiff;
    logic        n_mfix;
    logic [6:0]  n_ssub;
    t_tod        n_tod;

    // Hour: reciprocal estimate, remainder, one correction.
    assign n_hprod = {6'd0, i_sod} * HR_RECIP;
    assign n_hback = {12'd0, r_hq1} * SECS_HOUR;
    assign n_hdiff = r_sod1 - n_hback;

    always_comb begin
        n_hfix = (r_hrem >= SECS_HOUR[12:0]);
        n_hsub = r_hrem - SECS_HOUR[12:0];
        n_hour = r_hq2 + {4'd0, n_hfix};
        n_mrem = n_hfix ? n_hsub[11:0] : r_hrem[11:0];
    end

    // Minute and second from the seconds within the hour.
    assign n_mprod = {7'd0, r_mrem2_3} * MN_RECIP;
    assign n_mback = {6'd0, r_mq} * SECS_MIN;
    assign n_mdiff = r_mrem2_4 - n_mback;

    always_comb begin
        n_mfix        = (r_srem >= SECS_MIN[6:0]);
        n_ssub        = r_srem - SECS_MIN[6:0];
        n_tod.hour    = r_hour[TD5];
        n_tod.minute  = r_mq4 + {5'd0, n_mfix};
        n_tod.second  = n_mfix ? n_ssub[5:0] : r_srem[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[TD0]) begin
            r_sod1 <= i_sod;
            r_hq1  <= n_hprod[21:17];
        end
        if (i_en[TD1]) begin
            r_hq2  <= r_hq1;
            r_hrem <= n_hdiff[12:0];
        end
        if (i_en[TD2]) begin
            r_hour[TD3] <= n_hour;
            r_mrem2_3   <= n_mrem;
        end
        if (i_en[TD3]) begin
            r_hour[TD4] <= r_hour[TD3];
            r_mrem2_4   <= r_mrem2_3;
            r_mq        <= n_mprod[17:12];
        end
        if (i_en[TD4]) begin
            r_hour[TD5] <= r_hour[TD4];
            r_mq4       <= r_mq;
            r_srem      <= n_mdiff[6:0];
        end
        if (i_en[TD5]) begin
            r_dly[TD5] <= n_tod;
        end
        for (int k = TDLY_FIRST; k < NUM_STAGES; k++) begin
            if (i_en[k]) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_hour   = r_dly[NUM_STAGES-1].hour;
    assign o_minute = r_dly[NUM_STAGES-1].minute;
    assign o_second = r_dly[NUM_STAGES-1].second;

endmodule

>>> rtl/core/seconds_to_calendar_date_time.sv
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+----------------------------------------
// request  | in        | i_in_valid / o_in_ready     | i_seconds_since_2000
// result   | out       | o_out_valid / i_out_ready   | o_year o_month o_day o_hour o_minute
//          |           |                             | o_second
//
// One request enters per clock unless a stalled result has filled the pipeline.
// The depth is set by the constant-reciprocal divisions, each spread over a multiply,
// a multiply-back and a correction stage.
// Reset clears only the stage valid bits; the data registers carry no reset.
// A stalled result holds the last stage while empty stages upstream keep filling,
// so bubbles close up and nothing is dropped or repeated.
module seconds_to_calendar_date_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_seconds_since_2000,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import stcd_pkg::*;

    t_stage_en   r_vld;
    t_stage_en   n_vld;
    t_stage_en   w_en;
    logic        w_hole;
    logic [15:0] w_days;
    logic [16:0] w_sod;

    // A stage may load when it or any stage after it is empty, or the result is taken.
    always_comb begin
        w_hole = 1'b0;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_hole  = w_hole | ~r_vld[k];
            w_en[k] = w_hole | i_out_ready;
        end
    end

    // Valid bits move with the data.
    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

    // Epoch shift and split into day number and seconds of the day.
    stcd_split u_split (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_seconds (i_seconds_since_2000),
        .o_days    (w_days),
        .o_sod     (w_sod)
    );

    // Day number to Gregorian year, month and day.
    stcd_date u_date (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_days  (w_days),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day)
    );

    // Seconds of the day to hour, minute and second.
    stcd_tod u_tod (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sod    (w_sod),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

endmodule

>>> rtl/core/stcd_check.sv
module stcd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_seconds_since_2000,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second
);

    // A result that is not taken stays in place unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_year) && $stable(o_month)
            && $stable(o_day) && $stable(o_hour) && $stable(o_minute) && $stable(o_second))
        else $error("result changed or vanished while stalled");

    // Every result field lies within its legal range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_year >= 12'd1970 && o_year <= 12'd2106 && o_month >= 4'd1
            && o_month <= 4'd12 && o_day >= 5'd1 && o_day <= 5'd31 && o_hour <= 5'd23
            && o_minute <= 6'd59 && o_second <= 6'd59)
        else $error("result field out of range");

    // With no result waiting, the pipeline always has room for a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused while output stage is empty");

    // When a result is taken, a request can be taken in the same cycle.
    a_ready_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |-> o_in_ready)
        else $error("request refused while pipeline advances");

endmodule

bind seconds_to_calendar_date_time stcd_check u_stcd_check (.*);

>>> bench/calendar_compare.sv
`timescale 1ns / 100ps

// Watches both channels of the calendar converter, predicts the date and
// time of day for every accepted request, and compares each accepted result
// against the oldest prediction still waiting.
module calendar_compare (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_seconds_since_2000,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal_stamp;

    localparam int unsigned MAX_REPORTS = 10;

    t_cal_stamp dates_due [$];
    int         bad_dates = 0;

    // Move the stamp to the 1970 epoch with a 32-bit wrap, then turn the
    // day count into a Gregorian date through the Julian day number.
    function automatic t_cal_stamp split_stamp(input logic [31:0] stamp);
        logic [31:0]     unix_secs;
        longint unsigned jdn;
        longint unsigned cent_blocks;
        longint unsigned yr_part;
        longint unsigned mon_idx;
        longint unsigned mday;
        longint unsigned yr_carry;
        t_cal_stamp      r;
        unix_secs   = stamp + 32'd946684800;
        jdn         = longint'(unix_secs / 32'd86400) + 64'd2509157;
        cent_blocks = (64'd4 * jdn) / 64'd146097;
        jdn         = jdn - (64'd146097 * cent_blocks + 64'd3) / 64'd4;
        yr_part     = (64'd4000 * (jdn + 64'd1)) / 64'd1461001;
        jdn         = jdn - (64'd1461 * yr_part) / 64'd4 + 64'd31;
        mon_idx     = (64'd80 * jdn) / 64'd2447;
        mday        = jdn - (64'd2447 * mon_idx) / 64'd80;
        yr_carry    = mon_idx / 64'd11;
        mon_idx     = mon_idx + 64'd2 - 64'd12 * yr_carry;
        yr_part     = 64'd100 * (cent_blocks - 64'd49) + yr_part + yr_carry;
        r.year      = yr_part[11:0];
        r.month     = mon_idx[3:0];
        r.day       = mday[4:0];
        r.hour      = 5'((unix_secs / 32'd3600) % 32'd24);
        r.minute    = 6'((unix_secs / 32'd60) % 32'd60);
        r.second    = 6'(unix_secs % 32'd60);
        return r;
    endfunction

    // Count a bad result and print the first few of them in full.
    task automatic log_bad_date(input string why, input t_cal_stamp want,
                                input t_cal_stamp got);
        bad_dates = bad_dates + 1;
        if (bad_dates <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                     $realtime, why, want.year, want.month, want.day, want.hour,
                     want.minute, want.second, got.year, got.month, got.day,
                     got.hour, got.minute, got.second);
        end
    endtask

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin : watch_channels
        t_cal_stamp got;
        t_cal_stamp want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                dates_due.push_back(split_stamp(i_seconds_since_2000));
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_year, i_month, i_day, i_hour, i_minute, i_second};
                if (dates_due.size() == 0) begin
                    log_bad_date("result with no request waiting", '0, got);
                end else begin
                    want = dates_due.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.hour !== want.hour ||
                        got.minute !== want.minute || got.second !== want.second) begin
                        log_bad_date("date mismatch", want, got);
                    end
                end
            end
        end
        o_pending    = dates_due.size();
        o_fail_count = bad_dates;
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

// Drives timestamps into the calendar converter, stalls results at random,
// and judges by the comparison unit's failure and pending counts.
module tb_top;

    import stcd_pkg::NUM_STAGES;

    localparam int unsigned RANDOM_STAMPS = 1330;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned BLOCK_AT      = 400;
    localparam int unsigned BLOCK_CYCLES  = 300;
    localparam logic [31:0] WRAP_POINT    = 32'd3348282496;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [31:0] in_seconds = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int unsigned sent_count = 0;
    logic        no_gaps = 1'b0;
    logic        sink_blocked = 1'b0;
    int unsigned sink_wait = 0;

    // Day, month, leap-year, century and epoch-wrap corners.
    logic [31:0] corner_stamps [23] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd5097599, 32'd5097600, 32'd5183999, 32'd5184000, 32'd31622399,
        32'd31622400, 32'd3160857599, 32'd3160857600, WRAP_POINT - 32'd1,
        WRAP_POINT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    seconds_to_calendar_date_time DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_seconds_since_2000 (in_seconds),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_year               (out_year),
        .o_month              (out_month),
        .o_day                (out_day),
        .o_hour               (out_hour),
        .o_minute             (out_minute),
        .o_second             (out_second)
    );

    calendar_compare u_compare (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_seconds_since_2000 (in_seconds),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_year               (out_year),
        .i_month              (out_month),
        .i_day                (out_day),
        .i_hour               (out_hour),
        .i_minute             (out_minute),
        .i_second             (out_second),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_stamp(input logic [31:0] stamp);
        int unsigned gap;
        gap = (no_gaps || sink_blocked) ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_seconds <= stamp;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent_count = sent_count + 1;
    endtask

    // Mostly uniform stamps, with extra weight near midnight, near the
    // epoch wrap and in the first days after the base date.
    function automatic logic [31:0] draw_stamp();
        longint unsigned base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom();
            5, 6, 7: begin
                base = longint'($urandom_range(0, 49709)) * 64'd86400;
                return 32'(base) + 32'($urandom_range(0, 5)) - 32'd3;
            end
            8: return WRAP_POINT + 32'($urandom_range(0, 200)) - 32'd100;
            default: return 32'($urandom_range(0, 200000));
        endcase
    endfunction

    // Result side: after each taken result, drop ready for a drawn number
    // of cycles, unless a no-gap stretch or the long block is in force.
    always @(posedge i_clk) begin : result_sink
        int unsigned pause;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end else if (sink_blocked) begin
            out_ready <= 1'b0;
        end else if (out_ready) begin
            if (out_valid) begin
                pause = no_gaps ? 0 : $urandom_range(0, 16);
                if (pause != 0) begin
                    out_ready <= 1'b0;
                    sink_wait <= pause - 1;
                end
            end
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // One long hold-off on the result side while requests keep coming.
    initial begin : long_block
        wait (sent_count >= BLOCK_AT);
        @(posedge i_clk);
        sink_blocked <= 1'b1;
        repeat (BLOCK_CYCLES) @(posedge i_clk);
        sink_blocked <= 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("seconds_to_calendar_date_time: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_stamps[idx]) send_stamp(corner_stamps[idx]);

        for (int unsigned n = 0; n < RANDOM_STAMPS; n++) begin
            // Switch between back-to-back stretches and random gaps.
            if (n % 150 == 0) no_gaps <= ($urandom_range(0, 3) == 0);
            send_stamp(draw_stamp());
        end
        in_valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray result.
        while (pending != 0) @(posedge i_clk);
        repeat (4 * NUM_STAGES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("seconds_to_calendar_date_time: match");
        end else begin
            $display("seconds_to_calendar_date_time: mismatch");
        end
        $finish;
    end

endmodule

>>> seconds_to_calendar_date_time.f
rtl/core/stcd_pkg.sv
rtl/core/stcd_split.sv
rtl/core/stcd_date.sv
rtl/core/stcd_tod.sv
rtl/core/seconds_to_calendar_date_time.sv
rtl/core/stcd_check.sv
bench/calendar_compare.sv
bench/tb_top.sv
